// ===== sv/rescale_and_bit_merge_pixels_defines.svh =====
// Assertion helpers used by rescale_and_bit_merge_pixels.sv.
// Each macro expects clk_i and rst_ni in scope.
`ifndef RESCALE_AND_BIT_MERGE_PIXELS_DEFINES_SVH
`define RESCALE_AND_BIT_MERGE_PIXELS_DEFINES_SVH

// Same-cycle implication.
`define RBMP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RBMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rbmp_pkg.sv =====
`timescale 1ns / 1ps

package rbmp_pkg;

  localparam int VAL_W       = 8;
  localparam int WIN_W       = 17;
  localparam int DIFF_W      = WIN_W + 1;
  localparam int MAG_W       = 17;
  localparam int NUM_W       = MAG_W + 8;
  localparam int SLICE_W     = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int DIV_STAGES  = 4;
  // difference, magnitude, scale-by-255 and the divider stages
  localparam int LANE_STAGES = 3 + DIV_STAGES;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_LOW   = 3'd0,
    CFG_IN_HIGH  = 3'd1,
    CFG_OUT_LOW  = 3'd2,
    CFG_OUT_HIGH = 3'd3,
    CFG_SLICE    = 3'd4
  } rbmp_cfg_idx_e;

  typedef struct packed {
    logic [VAL_W-1:0] new_value;
    logic [VAL_W-1:0] old_value;
    logic             last_in;
  } rbmp_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] merged_value;
    logic             last_out;
  } rbmp_out_t;

  // Divider state carried from stage to stage.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [MAG_W-1:0] dvs;
    logic [VAL_W-1:0] quo;
    logic             zero;
    logic             sat;
  } rbmp_div_t;

  function automatic logic [VAL_W-1:0] top_mask(logic [SLICE_W-1:0] nb);
    logic [VAL_W-1:0] m;
    case (nb)
      4'd0:    m = 8'h00;
      4'd1:    m = 8'h80;
      4'd2:    m = 8'hC0;
      4'd3:    m = 8'hE0;
      4'd4:    m = 8'hF0;
      4'd5:    m = 8'hF8;
      4'd6:    m = 8'hFC;
      4'd7:    m = 8'hFE;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/rescale_and_bit_merge_pixels.sv =====
// Rescales each byte of a voxel pair through its own window,
// r = trunc((v - low) * 255 / (high - low)) clamped to 0..255 (0 for an empty
// window), then merges them: the rescaled old byte shifted right by slice_bits,
// with the top slice_bits bits of the rescaled new byte ORed in (9..15 act as 8).
// Throughput is one item per cycle while the output is not stalled; each
// item passes through the 7-stage rescale lanes (offset, magnitude, scale
// by 255, and a 4-stage divider that resolves two quotient bits per stage)
// and then the output register. Stalls ripple back stage by stage, so empty
// stages keep filling while a result waits. Write configuration only while
// no item is in flight; writes to unlisted indexes are dropped.
`timescale 1ns / 1ps
`include "rescale_and_bit_merge_pixels_defines.svh"

module rescale_and_bit_merge_pixels (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rbmp_pkg::rbmp_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rbmp_pkg::rbmp_out_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [rbmp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbmp_pkg::WIN_W-1:0]      cfg_wdata_i
);
  import rbmp_pkg::*;

  localparam int LAST = LANE_STAGES - 1;

  // Configuration registers
  logic [WIN_W-1:0]   in_low_q, in_high_q, out_low_q, out_high_q;
  logic [SLICE_W-1:0] slice_q;

  // Pipeline control
  logic [LANE_STAGES-1:0] vq_q;
  logic [LANE_STAGES-1:0] adv;
  logic                   out_rdy;
  logic                   out_valid_q;
  rbmp_out_t              out_data_d, out_data_q;
  logic                   last_q [LANE_STAGES];

  logic [VAL_W-1:0]   new_scaled, old_scaled;
  logic [SLICE_W-1:0] nb;

  // Write a register when enabled; drop unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_low_q   <= '0;
      in_high_q  <= WIN_W'(255);
      out_low_q  <= '0;
      out_high_q <= WIN_W'(255);
      slice_q    <= SLICE_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IN_LOW:   in_low_q   <= cfg_wdata_i;
        CFG_IN_HIGH:  in_high_q  <= cfg_wdata_i;
        CFG_OUT_LOW:  out_low_q  <= cfg_wdata_i;
        CFG_OUT_HIGH: out_high_q <= cfg_wdata_i;
        CFG_SLICE:    slice_q    <= cfg_wdata_i[SLICE_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    out_rdy   = !out_valid_q || out_ready_i;
    adv[LAST] = !vq_q[LAST] || out_rdy;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vq_q[k] || adv[k + 1];
    end
  end

  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv[0]) begin
        vq_q[0] <= in_valid_i;
      end
      for (int k = 1; k < LANE_STAGES; k++) begin
        if (adv[k]) begin
          vq_q[k] <= vq_q[k - 1];
        end
      end
      if (out_rdy) begin
        out_valid_q <= vq_q[LAST];
      end
    end
  end

  // Carry the end-of-buffer flag alongside the lanes.
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      last_q[0] <= in_data_i.last_in;
    end
    for (int k = 1; k < LANE_STAGES; k++) begin
      if (adv[k]) begin
        last_q[k] <= last_q[k - 1];
      end
    end
  end

  rbmp_lane u_new_lane (
    .clk_i      (clk_i),
    .en_i       (adv),
    .value_i    (in_data_i.new_value),
    .win_low_i  (in_low_q),
    .win_high_i (in_high_q),
    .scaled_o   (new_scaled)
  );

  rbmp_lane u_old_lane (
    .clk_i      (clk_i),
    .en_i       (adv),
    .value_i    (in_data_i.old_value),
    .win_low_i  (out_low_q),
    .win_high_i (out_high_q),
    .scaled_o   (old_scaled)
  );

  // Merge: saturate the slice width at a full byte.
  always_comb begin
    nb = (slice_q > SLICE_W'(VAL_W)) ? SLICE_W'(VAL_W) : slice_q;
    out_data_d.merged_value = (old_scaled >> nb) | (top_mask(nb) & new_scaled);
    out_data_d.last_out     = last_q[LAST];
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `RBMP_ASSERT_IMP(a_ready_when_out_free, !out_valid_o, in_ready_o, "input stalled with free output")
  `RBMP_ASSERT_NEXT(a_tail_holds, vq_q[LAST] && !adv[LAST], vq_q[LAST] && $stable(last_q[LAST]), "tail item lost in stall")
  `RBMP_ASSERT_IMP(a_out_from_tail, $rose(out_valid_o), $past(vq_q[LAST]), "result without tail item")

endmodule

// ===== sv/rbmp_div_stage.sv =====
`timescale 1ns / 1ps

module rbmp_div_stage #(
  parameter int BIT_HI = 7
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  rbmp_pkg::rbmp_div_t d_i,
  output rbmp_pkg::rbmp_div_t d_o
);
  import rbmp_pkg::*;

  logic [NUM_W-1:0] trial_hi;
  logic [NUM_W-1:0] trial_lo;
  logic [NUM_W-1:0] rem_mid;
  logic             bit_hi;
  logic             bit_lo;
  rbmp_div_t        div_d;
  rbmp_div_t        div_q;

  // Two restoring steps per stage.
  always_comb begin
    trial_hi = NUM_W'(d_i.dvs) << BIT_HI;
    bit_hi   = (d_i.rem >= trial_hi);
    rem_mid  = bit_hi ? (d_i.rem - trial_hi) : d_i.rem;
    trial_lo = NUM_W'(d_i.dvs) << (BIT_HI - 1);
    bit_lo   = (rem_mid >= trial_lo);
    div_d            = d_i;
    div_d.rem        = bit_lo ? (rem_mid - trial_lo) : rem_mid;
    div_d.quo[BIT_HI]     = bit_hi;
    div_d.quo[BIT_HI - 1] = bit_lo;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign d_o = div_q;

endmodule

// ===== sv/rbmp_lane.sv =====
`timescale 1ns / 1ps

module rbmp_lane (
  input  logic                                clk_i,
  input  logic [rbmp_pkg::LANE_STAGES-1:0]    en_i,
  input  logic [rbmp_pkg::VAL_W-1:0]          value_i,
  input  logic [rbmp_pkg::WIN_W-1:0]          win_low_i,
  input  logic [rbmp_pkg::WIN_W-1:0]          win_high_i,
  output logic [rbmp_pkg::VAL_W-1:0]          scaled_o
);
  import rbmp_pkg::*;

  logic signed [DIFF_W-1:0] diff_d, diff_q;
  logic signed [DIFF_W-1:0] span_d, span_q;
  logic [DIFF_W-1:0]        diff_abs, span_abs;
  logic [MAG_W-1:0]         mag_diff_q, mag_span_q;
  logic                     zero_d, zero_q;
  logic [NUM_W-1:0]         num;
  rbmp_div_t                div_d, div_q;
  rbmp_div_t                chain [DIV_STAGES+1];

  // Stage 1: offsets from the window low edge.
  always_comb begin
    diff_d = $signed({{(DIFF_W-VAL_W){1'b0}}, value_i}) - $signed({win_low_i[WIN_W-1], win_low_i});
    span_d = $signed({win_high_i[WIN_W-1], win_high_i})
           - $signed({win_low_i[WIN_W-1], win_low_i});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      diff_q <= diff_d;
      span_q <= span_d;
    end
  end

  // Stage 2: magnitudes; opposite signs or an empty window clamp to zero.
  always_comb begin
    diff_abs = diff_q[DIFF_W-1] ? (~diff_q + 1'b1) : diff_q;
    span_abs = span_q[DIFF_W-1] ? (~span_q + 1'b1) : span_q;
    zero_d   = (span_q == '0) || (diff_q[DIFF_W-1] != span_q[DIFF_W-1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mag_diff_q <= diff_abs[MAG_W-1:0];
      mag_span_q <= span_abs[MAG_W-1:0];
      zero_q     <= zero_d;
    end
  end

  // Stage 3: times 255 by shift and subtract; flag quotients past 255.
  always_comb begin
    num        = {mag_diff_q, 8'h00} - NUM_W'(mag_diff_q);
    div_d.rem  = num;
    div_d.dvs  = mag_span_q;
    div_d.quo  = '0;
    div_d.zero = zero_q;
    div_d.sat  = (num >= {mag_span_q, 8'h00});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      div_q <= div_d;
    end
  end

  assign chain[0] = div_q;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    rbmp_div_stage #(
      .BIT_HI (VAL_W - 1 - 2 * g)
    ) u_div_stage (
      .clk_i (clk_i),
      .en_i  (en_i[3 + g]),
      .d_i   (chain[g]),
      .d_o   (chain[g + 1])
    );
  end

  always_comb begin
    if (chain[DIV_STAGES].zero) begin
      scaled_o = '0;
    end else if (chain[DIV_STAGES].sat) begin
      scaled_o = '1;
    end else begin
      scaled_o = chain[DIV_STAGES].quo;
    end
  end

endmodule
